// ===== hw/rtl/tsq_pkg.sv =====
// Shared types and codes for the two-stack queue unit.
// No dependencies; used by the sequencer and the top level.
package tsq_pkg;

  // Width of one queue entry.
  localparam int DATA_W = 32;

  // Action codes carried on the input tuser.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes carried on the output tuser.
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  // One finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic                    load;
    status_t                 status;
    logic [DATA_W-1:0]       data;
  } rslt_t;

endpackage

// ===== hw/rtl/tsq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; instanced once for each stack.
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tsq_seq.sv =====
// Sequencer of the two-stack queue: stack counts, transfer loop and pops.
// Depends on tsq_pkg; drives the address and write ports of both stack RAMs.
module tsq_seq #(
  parameter int DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [tsq_pkg::DATA_W-1:0]       in_data,
  input  logic                             out_free,
  output tsq_pkg::rslt_t                   rslt,
  // Input stack RAM.
  output logic                             istk_we,
  output logic [$clog2(DEPTH)-1:0]         istk_waddr,
  output logic [tsq_pkg::DATA_W-1:0]       istk_wdata,
  output logic [$clog2(DEPTH)-1:0]         istk_raddr,
  input  logic [tsq_pkg::DATA_W-1:0]       istk_rdata,
  // Output stack RAM.
  output logic                             ostk_we,
  output logic [$clog2(DEPTH)-1:0]         ostk_waddr,
  output logic [tsq_pkg::DATA_W-1:0]       ostk_wdata,
  output logic [$clog2(DEPTH)-1:0]         ostk_raddr,
  input  logic [tsq_pkg::DATA_W-1:0]       ostk_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_XFER     = 4'b0010,
    ST_POP_RD   = 4'b0100,
    ST_POP_WAIT = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] icnt, icnt_next;
  logic [CW-1:0] ocnt, ocnt_next;
  logic          pend, pend_next;
  logic [CW-1:0] icnt_m1, ocnt_m1;
  logic          accept;

  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign icnt_m1  = icnt - 1'b1;
  assign ocnt_m1  = ocnt - 1'b1;

  // Next-state logic. During a transfer one entry is read from the input
  // stack each cycle and written to the output stack in the following cycle.
  always_comb begin
    state_next = state;
    icnt_next  = icnt;
    ocnt_next  = ocnt;
    pend_next  = pend;

    istk_we    = 1'b0;
    istk_waddr = icnt[AW-1:0];
    istk_wdata = in_data;
    istk_raddr = icnt_m1[AW-1:0];
    ostk_we    = 1'b0;
    ostk_waddr = ocnt[AW-1:0];
    ostk_wdata = istk_rdata;
    ostk_raddr = ocnt_m1[AW-1:0];

    rslt.load   = 1'b0;
    rslt.status = tsq_pkg::STAT_OK;
    rslt.data   = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == tsq_pkg::ACT_ENQ) begin
            rslt.load = 1'b1;
            if (icnt == FULL_CNT) begin
              rslt.status = tsq_pkg::STAT_FULL;
            end else begin
              istk_we   = 1'b1;
              icnt_next = icnt + 1'b1;
            end
          end else if (ocnt != '0) begin
            state_next = ST_POP_RD;
          end else if (icnt != '0) begin
            state_next = ST_XFER;
          end else begin
            rslt.load   = 1'b1;
            rslt.status = tsq_pkg::STAT_EMPTY;
          end
        end
      end
      ST_XFER: begin
        if (pend) begin
          ostk_we   = 1'b1;
          ocnt_next = ocnt + 1'b1;
        end
        pend_next = (icnt != '0);
        if (icnt != '0) begin
          icnt_next = icnt_m1;
        end else if (!pend) begin
          state_next = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        ocnt_next  = ocnt_m1;
        state_next = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        rslt.load  = 1'b1;
        rslt.data  = ostk_rdata;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      icnt  <= '0;
      ocnt  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      icnt  <= icnt_next;
      ocnt  <= ocnt_next;
      pend  <= pend_next;
    end
  end

endmodule

// ===== hw/rtl/two_stack_fifo_queue_unit.sv =====
// Top level of the two-stack queue unit: stack RAMs, sequencer, output register.
// Depends on tsq_pkg, tsq_ram and tsq_seq.
//
// A first-in first-out queue of DEPTH signed 32-bit values built from an input
// stack and an output stack, each a RAM with a registered read. Every input
// beat yields exactly one result beat. An enqueue or a dequeue of an empty
// queue loads its result into the output register in the cycle it is
// accepted. A dequeue while the output stack holds entries goes through
// accept, RAM read and result. A dequeue that finds the output stack empty
// first moves all n entries of the input stack over, one entry a cycle
// through the read port of the input RAM and the write port of the output
// RAM. Each entry moves only once. The input is not ready while a dequeue is
// in progress, or while a result waits and is not being taken.
module two_stack_fifo_queue_unit #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_in
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data_out
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);

  tsq_pkg::rslt_t                rslt;
  logic                          out_free;
  logic                          istk_we, ostk_we;
  logic [AW-1:0]                 istk_waddr, istk_raddr, ostk_waddr, ostk_raddr;
  logic [tsq_pkg::DATA_W-1:0]    istk_wdata, istk_rdata, ostk_wdata, ostk_rdata;
  tsq_pkg::status_t              out_status;
  logic [tsq_pkg::DATA_W-1:0]    out_data;

  assign out_free = !m_tvalid || m_tready;

  tsq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser[0]),
    .in_data    (s_tdata),
    .out_free   (out_free),
    .rslt       (rslt),
    .istk_we    (istk_we),
    .istk_waddr (istk_waddr),
    .istk_wdata (istk_wdata),
    .istk_raddr (istk_raddr),
    .istk_rdata (istk_rdata),
    .ostk_we    (ostk_we),
    .ostk_waddr (ostk_waddr),
    .ostk_wdata (ostk_wdata),
    .ostk_raddr (ostk_raddr),
    .ostk_rdata (ostk_rdata)
  );

  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_istk (
    .clk   (clk),
    .we    (istk_we),
    .waddr (istk_waddr),
    .wdata (istk_wdata),
    .raddr (istk_raddr),
    .rdata (istk_rdata)
  );

  tsq_ram #(.WIDTH(tsq_pkg::DATA_W), .DEPTH(DEPTH)) u_ostk (
    .clk   (clk),
    .we    (ostk_we),
    .waddr (ostk_waddr),
    .wdata (ostk_wdata),
    .raddr (ostk_raddr),
    .rdata (ostk_rdata)
  );

  // Output register: holds one result beat until the master side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rslt.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rslt.load) begin
      out_status <= rslt.status;
      out_data   <= rslt.data;
    end
  end

  assign m_tdata = out_data;
  assign m_tuser = out_status;

endmodule
